[src/hvt_pkg.sv]
// ----------------------------------------------------------------------------
// hvt_pkg
// Shared widths, types and reset constants for the homogeneous vector transform.
// ----------------------------------------------------------------------------
`default_nettype none

package hvt_pkg;

    // number format
    localparam int FRAC_BITS = 16;
    localparam int ELEM_W    = 32;

    // vector and matrix shape
    localparam int DIM       = 4;
    localparam int NUM_REGS  = 8;
    localparam int REG_W     = 2 * ELEM_W;
    localparam int IDX_W     = $clog2(NUM_REGS);

    // datapath widths: exact product, pair sum, total sum, shifted sum
    localparam int PROD_W    = 2 * ELEM_W;
    localparam int PAIR_W    = PROD_W + 1;
    localparam int SUM_W     = PROD_W + 2;
    localparam int SHR_W     = SUM_W - FRAC_BITS;

    // register indexes
    localparam logic [IDX_W-1:0] REG_COL0_ROWS01 = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_COL0_ROWS23 = IDX_W'(1);
    localparam logic [IDX_W-1:0] REG_COL1_ROWS01 = IDX_W'(2);
    localparam logic [IDX_W-1:0] REG_COL1_ROWS23 = IDX_W'(3);
    localparam logic [IDX_W-1:0] REG_COL2_ROWS01 = IDX_W'(4);
    localparam logic [IDX_W-1:0] REG_COL2_ROWS23 = IDX_W'(5);
    localparam logic [IDX_W-1:0] REG_COL3_ROWS01 = IDX_W'(6);
    localparam logic [IDX_W-1:0] REG_COL3_ROWS23 = IDX_W'(7);

    // fixed-point one and the identity register contents
    localparam logic [REG_W-1:0] ONE_LO = REG_W'(64'd1 << FRAC_BITS);
    localparam logic [REG_W-1:0] ONE_HI = ONE_LO << ELEM_W;

    typedef logic signed [ELEM_W-1:0] elem_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [PAIR_W-1:0] pair_t;
    typedef logic signed [SUM_W-1:0]  sum_t;
    typedef logic signed [SHR_W-1:0]  shr_t;

    typedef elem_t vec_t [DIM];
    typedef elem_t mat_t [DIM][DIM];  // [row][col]

    // stage load enables for one lane
    typedef struct packed {
        logic en_mul;
        logic en_pair;
        logic en_sum;
    } lane_ctl_t;

    // identity matrix contents of each register
    function automatic logic [REG_W-1:0] reg_reset_value(input logic [IDX_W-1:0] idx);
        logic [REG_W-1:0] val;
        begin
            unique case (idx)
                REG_COL0_ROWS01: val = ONE_LO;
                REG_COL1_ROWS01: val = ONE_HI;
                REG_COL2_ROWS23: val = ONE_LO;
                REG_COL3_ROWS23: val = ONE_HI;
                default:         val = '0;
            endcase
            return val;
        end
    endfunction

endpackage

`default_nettype wire

[src/hvt_if.sv]
// ----------------------------------------------------------------------------
// hvt_if
// Valid/ready channels for input vertices and transformed results.
// ----------------------------------------------------------------------------
`default_nettype none

// input vertex channel
interface hvt_in_if
    import hvt_pkg::*;
();
    logic  valid;
    logic  ready;
    elem_t in_x;
    elem_t in_y;
    elem_t in_z;
    elem_t in_w;

    modport source (output valid, output in_x, output in_y, output in_z, output in_w,
                    input ready);
    modport sink   (input valid, input in_x, input in_y, input in_z, input in_w,
                    output ready);
endinterface

// result channel
interface hvt_out_if
    import hvt_pkg::*;
();
    logic  valid;
    logic  ready;
    elem_t out_x;
    elem_t out_y;
    elem_t out_z;
    elem_t out_w;
    logic  overflow;

    modport source (output valid, output out_x, output out_y, output out_z, output out_w,
                    output overflow, input ready);
    modport sink   (input valid, input out_x, input out_y, input out_z, input out_w,
                    input overflow, output ready);
endinterface

`default_nettype wire

[src/homogeneous_vector_transform.sv]
// ----------------------------------------------------------------------------
// homogeneous_vector_transform
// 4x4 column-major matrix times homogeneous vector, signed Q16.16 fixed point.
// ----------------------------------------------------------------------------
// Takes one vector word per cycle and returns one result word per cycle in
// steady state, unless the result channel holds back. A word's result reaches
// the output register in order: the four multipliers of each row lane work in
// the cycle the word is offered and load at the accepting edge, then the pair
// sums are registered, then the exact total and floor shift, then saturation
// and the overflow merge. Four row lanes run side by side, sixteen 32x32
// multipliers in all. Each pipeline stage holds its word while the stage after
// it is full, so bubbles close up under back-pressure. The eight matrix
// registers reset to identity; the user must see that they are written only
// while the block is idle, which the block itself does not enforce.
`default_nettype none

module homogeneous_vector_transform
    import hvt_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_wr_en,
    input  wire logic [IDX_W-1:0] cfg_index,
    input  wire logic [REG_W-1:0] cfg_data,
    hvt_in_if.sink                vertex,
    hvt_out_if.source             result
);

    mat_t      mat;
    vec_t      vec;
    shr_t      lane_shr [DIM];
    lane_ctl_t ctl;

    logic v1_reg;
    logic v2_reg;
    logic v3_reg;
    logic free1;
    logic free2;
    logic free3;
    logic free4;

    // matrix registers
    hvt_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .mat       (mat)
    );

    // pipeline occupancy: a stage is free when empty or when its word moves on
    assign free3 = !v3_reg || free4;
    assign free2 = !v2_reg || free3;
    assign free1 = !v1_reg || free2;

    assign vertex.ready = free1;

    assign ctl.en_mul  = vertex.valid && free1;
    assign ctl.en_pair = v1_reg && free2;
    assign ctl.en_sum  = v2_reg && free3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (free1)
            begin
                v1_reg <= vertex.valid;
            end
            if (free2)
            begin
                v2_reg <= v1_reg;
            end
            if (free3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    assign vec[0] = vertex.in_x;
    assign vec[1] = vertex.in_y;
    assign vec[2] = vertex.in_z;
    assign vec[3] = vertex.in_w;

    // one lane per output component
    for (genvar r = 0; r < DIM; r++)
    begin : g_lane
        hvt_lane u_lane (
            .clk (clk),
            .ctl (ctl),
            .row (mat[r]),
            .vec (vec),
            .shr (lane_shr[r])
        );
    end

    // saturation, overflow merge and output register
    hvt_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .lane_valid (v3_reg),
        .lane_shr   (lane_shr),
        .free       (free4),
        .result     (result)
    );

endmodule

`default_nettype wire

[src/hvt_cfg.sv]
// ----------------------------------------------------------------------------
// hvt_cfg
// Matrix configuration registers, reset to identity, unpacked to row/column form.
// ----------------------------------------------------------------------------
`default_nettype none

module hvt_cfg
    import hvt_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_wr_en,
    input  wire logic [IDX_W-1:0] cfg_index,
    input  wire logic [REG_W-1:0] cfg_data,
    output mat_t                  mat
);

    logic [REG_W-1:0] col_reg [NUM_REGS];

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                col_reg[i] <= reg_reset_value(IDX_W'(i));
            end
        end
        else if (cfg_wr_en)
        begin
            col_reg[cfg_index] <= cfg_data;
        end
    end

    // element k = 4*col + row lives in register k/2, half k%2
    always_comb
    begin
        for (int r = 0; r < DIM; r++)
        begin
            for (int c = 0; c < DIM; c++)
            begin
                if ((((DIM * c) + r) % 2) == 1)
                begin
                    mat[r][c] = col_reg[((DIM * c) + r) / 2][REG_W-1:ELEM_W];
                end
                else
                begin
                    mat[r][c] = col_reg[((DIM * c) + r) / 2][ELEM_W-1:0];
                end
            end
        end
    end

endmodule

`default_nettype wire

[src/hvt_lane.sv]
// ----------------------------------------------------------------------------
// hvt_lane
// One row lane: four exact products, pair sums, total and floor shift.
// ----------------------------------------------------------------------------
`default_nettype none

module hvt_lane
    import hvt_pkg::*;
(
    input  wire logic      clk,
    input  wire lane_ctl_t ctl,
    input  wire vec_t      row,
    input  wire vec_t      vec,
    output shr_t           shr
);

    prod_t prod_reg [DIM];
    pair_t pair_reg [2];
    shr_t  shr_reg;
    sum_t  total;

    // stage 1: one multiplier per column
    always_ff @(posedge clk)
    begin
        if (ctl.en_mul)
        begin
            for (int c = 0; c < DIM; c++)
            begin
                prod_reg[c] <= PROD_W'(row[c]) * PROD_W'(vec[c]);
            end
        end
    end

    // stage 2: pair sums
    always_ff @(posedge clk)
    begin
        if (ctl.en_pair)
        begin
            pair_reg[0] <= PAIR_W'(prod_reg[0]) + PAIR_W'(prod_reg[1]);
            pair_reg[1] <= PAIR_W'(prod_reg[2]) + PAIR_W'(prod_reg[3]);
        end
    end

    // stage 3: exact total, floor shift by the fraction width
    always_comb
    begin
        total = SUM_W'(pair_reg[0]) + SUM_W'(pair_reg[1]);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en_sum)
        begin
            shr_reg <= total[SUM_W-1:FRAC_BITS];
        end
    end

    assign shr = shr_reg;

endmodule

`default_nettype wire

[src/hvt_merge.sv]
// ----------------------------------------------------------------------------
// hvt_merge
// Saturates the four lane sums, merges overflow flags, holds the result word.
// ----------------------------------------------------------------------------
`default_nettype none

module hvt_merge
    import hvt_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  lane_valid,
    input  wire shr_t  lane_shr [DIM],
    output logic       free,
    hvt_out_if.source  result
);

    elem_t sat      [DIM];
    logic  lane_ovf [DIM];
    logic  ovf_any;
    elem_t res_reg  [DIM];
    logic  ovf_reg;
    logic  valid_reg;

    // per-lane saturation: in range when the bits above bit 31 match the sign
    always_comb
    begin
        ovf_any = 1'b0;
        for (int r = 0; r < DIM; r++)
        begin
            lane_ovf[r] = !((&lane_shr[r][SHR_W-1:ELEM_W-1]) ||
                            !(|lane_shr[r][SHR_W-1:ELEM_W-1]));
            if (!lane_ovf[r])
            begin
                sat[r] = lane_shr[r][ELEM_W-1:0];
            end
            else if (lane_shr[r][SHR_W-1])
            begin
                sat[r] = {1'b1, {(ELEM_W-1){1'b0}}};
            end
            else
            begin
                sat[r] = {1'b0, {(ELEM_W-1){1'b1}}};
            end
            ovf_any = ovf_any | lane_ovf[r];
        end
    end

    // output word holds until taken
    assign free = !valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (free)
        begin
            valid_reg <= lane_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (free && lane_valid)
        begin
            for (int r = 0; r < DIM; r++)
            begin
                res_reg[r] <= sat[r];
            end
            ovf_reg <= ovf_any;
        end
    end

    assign result.valid    = valid_reg;
    assign result.out_x    = res_reg[0];
    assign result.out_y    = res_reg[1];
    assign result.out_z    = res_reg[2];
    assign result.out_w    = res_reg[3];
    assign result.overflow = ovf_reg;

endmodule

`default_nettype wire
